FILE: rtl/core/epsm_pkg.sv
// Package for the encoder period speed meter.
// Holds field widths, reset values, register indexes and the state and status codes.
// No dependencies.
package epsm_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned NUM_W      = 40;
    localparam int unsigned GLITCH_W   = 16;
    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned DIV_CNT_W  = 6;

    localparam logic [GLITCH_W-1:0]  GLITCH_RESET = 16'd1000;
    localparam logic [NUM_W-1:0]     NUM_RESET    = 40'd5147185403;
    localparam logic [TIME_W-1:0]    SPEED_MAX    = '1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(NUM_W - 1);

    typedef enum logic [0:0] {
        CFG_GLITCH_MIN = 1'b0,
        CFG_SPEED_NUM  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        EDGE_NONE      = 2'd0,
        EDGE_ACCEPTED  = 2'd1,
        EDGE_GLITCH    = 2'd2,
        EDGE_DUPLICATE = 2'd3
    } t_edge_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/core/encoder_period_speed_meter.sv
// Encoder period speed meter: glitch filter, two-interval period, serial speed divider.
// Depends on epsm_pkg for widths, reset values and codes.
//
// Usage: each input item carries an optional encoder edge (time, direction) and the
// current time; every item yields exactly one result item (speed, spoke count, status).
// Input and output channels use valid/ready; config is a plain write port (index 0:
// glitch threshold, index 1: speed numerator), which the user must write only while
// the block is idle; the block itself does not enforce this. An accepted edge runs a
// restoring divider, one quotient bit per cycle over the 40-bit numerator, and the
// finish state then moves its result to the output register. Items with no edge, a
// duplicate or a glitch skip the divider and go straight to the finish state.
// The block takes one item at a time; input ready is high only in the idle state.
// A result waits in the output register until taken; the next item is accepted
// meanwhile, and its result is held back until the output register frees up.
// Reset (synchronous, active low) clears edge history, speed and spoke count and
// restores the register defaults; the block is ready in the cycle after reset.
module encoder_period_speed_meter
    import epsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_edge_valid,
    input  logic [TIME_W-1:0]       i_edge_time,
    input  logic signed [1:0]       i_direction,
    input  logic [TIME_W-1:0]       i_now_time,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [TIME_W-1:0]       o_speed_q16,
    output logic signed [TIME_W-1:0] o_spoke_count,
    output logic [1:0]              o_edge_status
);

    t_state                  r_state, n_state;
    logic [GLITCH_W-1:0]     r_glitch, n_glitch;
    logic [NUM_W-1:0]        r_speed_num, n_speed_num;
    logic [TIME_W-1:0]       r_older, n_older;
    logic [TIME_W-1:0]       r_newest, n_newest;
    logic [TIME_W-1:0]       r_delta, n_delta;
    logic [TIME_W-1:0]       r_held, n_held;
    logic [TIME_W-1:0]       r_spoke, n_spoke;
    logic [TIME_W-1:0]       r_now, n_now;
    t_edge_status            r_status, n_status;
    logic [NUM_W-1:0]        r_dq, n_dq;
    logic [TIME_W-1:0]       r_rem, n_rem;
    logic [DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic [TIME_W-1:0]       r_out_speed, n_out_speed;
    logic [TIME_W-1:0]       r_out_spoke, n_out_spoke;
    t_edge_status            r_out_status, n_out_status;

    logic [TIME_W-1:0]       w_gap;
    logic [TIME_W:0]         w_trial;
    logic [TIME_W:0]         w_diff;
    logic                    w_fits;
    logic [TIME_W-1:0]       w_since;
    logic                    w_stale;
    logic                    w_out_free;

    assign w_gap      = i_edge_time - r_newest;
    assign w_trial    = {r_rem, r_dq[NUM_W-1]};
    assign w_diff     = w_trial - {1'b0, r_delta};
    assign w_fits     = (w_trial >= {1'b0, r_delta});
    assign w_since    = r_now - r_newest;
    assign w_stale    = ({1'b0, w_since} > {r_delta, 1'b0});
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_glitch     = r_glitch;
        n_speed_num  = r_speed_num;
        n_older      = r_older;
        n_newest     = r_newest;
        n_delta      = r_delta;
        n_held       = r_held;
        n_spoke      = r_spoke;
        n_now        = r_now;
        n_status     = r_status;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_speed  = r_out_speed;
        n_out_spoke  = r_out_spoke;
        n_out_status = r_out_status;
        o_in_ready   = (r_state == ST_IDLE);

        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GLITCH_MIN: n_glitch    = i_cfg_data[GLITCH_W-1:0];
                CFG_SPEED_NUM:  n_speed_num = i_cfg_data[NUM_W-1:0];
                default:        n_glitch    = r_glitch;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_now   = i_now_time;
                    n_state = ST_FINISH;
                    priority if (!i_edge_valid) begin
                        n_status = EDGE_NONE;
                    end else if (i_edge_time == r_newest) begin
                        n_status = EDGE_DUPLICATE;
                    end else if (w_gap < {{(TIME_W-GLITCH_W){1'b0}}, r_glitch}) begin
                        n_status = EDGE_GLITCH;
                    end else begin
                        n_status = EDGE_ACCEPTED;
                        n_delta  = i_edge_time - r_older;
                        n_older  = r_newest;
                        n_newest = i_edge_time;
                        n_spoke  = r_spoke + {{(TIME_W-2){i_direction[1]}}, i_direction};
                        n_dq     = r_speed_num;
                        n_rem    = '0;
                        n_cnt    = '0;
                        n_state  = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                n_rem = w_fits ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
                n_dq  = {r_dq[NUM_W-2:0], w_fits};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_held  = (|n_dq[NUM_W-1:TIME_W]) ? SPEED_MAX : n_dq[TIME_W-1:0];
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_speed  = w_stale ? '0 : r_held;
                    n_out_spoke  = r_spoke;
                    n_out_status = r_status;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_glitch    <= GLITCH_RESET;
            r_speed_num <= NUM_RESET;
            r_older     <= '0;
            r_newest    <= '0;
            r_delta     <= '0;
            r_held      <= '0;
            r_spoke     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_glitch    <= n_glitch;
            r_speed_num <= n_speed_num;
            r_older     <= n_older;
            r_newest    <= n_newest;
            r_delta     <= n_delta;
            r_held      <= n_held;
            r_spoke     <= n_spoke;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_status     <= n_status;
        r_dq         <= n_dq;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_out_speed  <= n_out_speed;
        r_out_spoke  <= n_out_spoke;
        r_out_status <= n_out_status;
    end

    assign o_out_valid   = r_out_valid;
    assign o_speed_q16   = r_out_speed;
    assign o_spoke_count = r_out_spoke;
    assign o_edge_status = r_out_status;

endmodule

FILE: dv/epsm_checker.sv
// Checker for the encoder period speed meter: watches the item channels and config port.
// Predicts each result from its own state copy, compares field by field, counts failures.
// Depends on epsm_pkg for widths, reset values, register indexes and status codes.
module epsm_checker
    import epsm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_edge_valid,
    input  logic [TIME_W-1:0]        i_edge_time,
    input  logic signed [1:0]        i_direction,
    input  logic [TIME_W-1:0]        i_now_time,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [TIME_W-1:0]        i_speed_q16,
    input  logic signed [TIME_W-1:0] i_spoke_count,
    input  logic [1:0]               i_edge_status,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TIME_W-1:0] speed;
        logic [TIME_W-1:0] spokes;
        t_edge_status      status;
    } t_reading;

    t_reading          expected_readings[$];
    int                fail_total = 0;

    logic [GLITCH_W-1:0] glitch_min;
    logic [NUM_W-1:0]    speed_num;
    logic [TIME_W-1:0]   older_edge;
    logic [TIME_W-1:0]   newest_edge;
    logic [TIME_W-1:0]   span_delta;
    logic [TIME_W-1:0]   held_speed;
    logic [TIME_W-1:0]   spoke_total;

    assign o_fail_count = fail_total;

    function automatic t_reading predict_reading(input logic ev,
            input logic [TIME_W-1:0] et, input logic [1:0] dir, input logic [TIME_W-1:0] now);
        t_reading          r;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] since;
        logic [NUM_W-1:0]  quot;
        r.status = EDGE_NONE;
        gap = et - newest_edge;
        if (ev) begin
            if (et == newest_edge) begin
                r.status = EDGE_DUPLICATE;
            end else if (gap < TIME_W'(glitch_min)) begin
                r.status = EDGE_GLITCH;
            end else begin
                r.status = EDGE_ACCEPTED;
                span_delta = et - older_edge;
                older_edge = newest_edge;
                newest_edge = et;
                if (span_delta == '0) begin
                    held_speed = '1;
                end else begin
                    quot = speed_num / NUM_W'(span_delta);
                    held_speed = (quot > NUM_W'(32'hFFFF_FFFF)) ? '1 : quot[TIME_W-1:0];
                end
                spoke_total = spoke_total + {{(TIME_W-2){dir[1]}}, dir};
            end
        end
        since = now - newest_edge;
        r.speed = ({1'b0, since} > {span_delta, 1'b0}) ? '0 : held_speed;
        r.spokes = spoke_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            glitch_min = GLITCH_RESET;
            speed_num = NUM_RESET;
            older_edge = '0;
            newest_edge = '0;
            span_delta = '0;
            held_speed = '0;
            spoke_total = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_GLITCH_MIN: glitch_min = i_cfg_data[GLITCH_W-1:0];
                    CFG_SPEED_NUM:  speed_num = i_cfg_data[NUM_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result item with no item pending");
                    fail_total++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_speed_q16 !== want.speed) begin
                        $error("speed_q16 mismatch: expected %0h, got %0h",
                               want.speed, i_speed_q16);
                        fail_total++;
                    end
                    if (i_spoke_count !== want.spokes) begin
                        $error("spoke_count mismatch: expected %0d, got %0d",
                               $signed(want.spokes), i_spoke_count);
                        fail_total++;
                    end
                    if (i_edge_status !== want.status) begin
                        $error("edge_status mismatch: expected %0d, got %0d",
                               want.status, i_edge_status);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_readings.push_back(predict_reading(i_edge_valid, i_edge_time,
                                                            i_direction, i_now_time));
            end
        end
        o_pending <= expected_readings.size();
    end

endmodule

FILE: dv/tb.sv
// Top of the encoder period speed meter testbench: clock, reset, stimulus and verdict.
// Drives edge items in bursts against a stalling receiver; epsm_checker does the checks.
// Depends on epsm_pkg, encoder_period_speed_meter and epsm_checker.
module tb;
    import epsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [0:0]               cfg_index = CFG_GLITCH_MIN;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     edge_valid = 1'b0;
    logic [TIME_W-1:0]        edge_time = '0;
    logic signed [1:0]        direction = '0;
    logic [TIME_W-1:0]        now_time = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [TIME_W-1:0]        speed_q16;
    logic signed [TIME_W-1:0] spoke_count;
    logic [1:0]               edge_status;
    int                       fail_count;
    int                       pending;

    logic [GLITCH_W-1:0]      stim_glitch = GLITCH_RESET;
    logic [TIME_W-1:0]        cursor = '0;
    int                       burst_left = 0;

    encoder_period_speed_meter i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_edge_valid  (edge_valid),
        .i_edge_time   (edge_time),
        .i_direction   (direction),
        .i_now_time    (now_time),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_speed_q16   (speed_q16),
        .o_spoke_count (spoke_count),
        .o_edge_status (edge_status)
    );

    epsm_checker meter_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_edge_valid  (edge_valid),
        .i_edge_time   (edge_time),
        .i_direction   (direction),
        .i_now_time    (now_time),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_speed_q16   (speed_q16),
        .i_spoke_count (spoke_count),
        .i_edge_status (edge_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic offer(input logic ev, input logic [TIME_W-1:0] et, input logic [1:0] dir,
            input logic [TIME_W-1:0] now);
        int gap;
        in_valid <= 1'b1;
        edge_valid <= ev;
        edge_time <= et;
        direction <= dir;
        now_time <= now;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 20);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_meter(input logic [GLITCH_W-1:0] glitch, input logic [NUM_W-1:0] num);
        wait_results_drained();
        cfg_we <= 1'b1;
        cfg_index <= CFG_GLITCH_MIN;
        cfg_data <= CFG_DATA_W'(glitch);
        @(posedge clk);
        cfg_index <= CFG_SPEED_NUM;
        cfg_data <= CFG_DATA_W'(num);
        @(posedge clk);
        cfg_we <= 1'b0;
        stim_glitch = glitch;
    endtask

    task automatic offer_random_item();
        int                pick;
        logic              ev;
        logic [1:0]        dir;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] et;
        logic [TIME_W-1:0] now;
        pick = $urandom_range(0, 99);
        ev = 1'b1;
        dir = 2'($urandom_range(0, 3));
        span = TIME_W'(stim_glitch) + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 300000)
                                                                 : $urandom_range(0, 3000));
        et = cursor + span;
        now = et + TIME_W'($urandom_range(0, 6 * span));
        if (pick < 60) begin
            cursor = et;
        end else if (pick < 70) begin
            et = cursor + TIME_W'($urandom_range(0, (stim_glitch > 0) ? stim_glitch - 1 : 0));
        end else if (pick < 75) begin
            et = cursor;
        end else if (pick < 90) begin
            ev = 1'b0;
            et = $urandom;
            now = (pick < 82) ? cursor + TIME_W'($urandom_range(0, 20000)) : $urandom;
        end else begin
            et = $urandom;
            now = $urandom;
            cursor = et;
        end
        offer(ev, et, dir, now);
    endtask

    initial begin : receiver
        int mode;
        int span;
        int round;
        round = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            round++;
            mode = (round % 40 == 5) ? 4 : $urandom_range(0, 3);
            span = (mode == 4) ? 400 : $urandom_range(10, 150);
            repeat (span) begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 5) == 0);
                    3: out_ready <= ~out_ready;
                    default: out_ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [GLITCH_W-1:0] glitch;
        logic [NUM_W-1:0]    num;
        int                  count;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(1'b0, 32'h0, 2'b01, 32'h0);
        offer(1'b1, 32'h0, 2'b01, 32'h0);
        offer(1'b1, 32'd500, 2'b01, 32'd500);
        offer(1'b1, 32'd1000, 2'b01, 32'd1000);
        offer(1'b1, 32'd3000, 2'b01, 32'd3000);
        offer(1'b0, 32'hFFFF_FFFF, 2'b11, 32'd9000);
        offer(1'b0, 32'h0, 2'b00, 32'd9001);
        offer(1'b1, 32'd1000, 2'b11, 32'd1000);
        offer(1'b1, 32'd3000, 2'b10, 32'd3000);
        offer(1'b1, 32'd3999, 2'b01, 32'd4000);
        offer(1'b1, 32'd3000, 2'b01, 32'd4000);
        offer(1'b1, 32'hFFFF_FFFF, 2'b00, 32'hFFFF_FFFF);
        offer(1'b1, 32'd999, 2'b01, 32'd999);
        offer(1'b0, 32'hFFFF_FFFF, 2'b10, 32'hFFFF_FFFF);

        program_meter('0, '1);
        offer(1'b1, 32'd1000, 2'b01, 32'd1000);
        offer(1'b1, 32'd1001, 2'b01, 32'd1001);
        offer(1'b1, 32'd1002, 2'b11, 32'd1002);

        program_meter('1, '0);
        offer(1'b1, 32'd66536, 2'b01, 32'd66536);
        offer(1'b1, 32'd66537, 2'b01, 32'd66537);
        offer(1'b0, $urandom, 2'b10, $urandom);
        cursor = 32'd66537;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin glitch = GLITCH_RESET; num = NUM_RESET; end
                1: begin glitch = '0; num = '1; end
                2: begin glitch = '1; num = NUM_W'({$urandom, $urandom}); end
                3: begin glitch = GLITCH_W'($urandom); num = '0; end
                4: begin glitch = GLITCH_W'($urandom_range(0, 2000));
                         num = NUM_W'({$urandom, $urandom}); end
                default: begin glitch = GLITCH_W'($urandom);
                               num = NUM_W'({$urandom_range(0, 1), $urandom}); end
            endcase
            program_meter(glitch, num);
            count = 0;
            while (count < 300) begin
                if (count == 150) wait_results_drained();
                offer_random_item();
                count++;
            end
        end

        wait_results_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
